// ----- hw/rtl/ghfc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ghfc_pkg: shared types and constants
// Field widths, register codes, reset values and the control bundles that
// pass between the stages of the homogeneity fire check.
// ----------------------------------------------------------------------------
package ghfc_pkg;

    localparam int PIX_W       = 8;
    localparam int GRAY_LEVELS = 2 ** PIX_W;
    localparam int DIM_W       = 11;
    localparam int THR_W       = 17;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int SUM_W       = 36;
    localparam int MIN_DIM     = 2;

    localparam int MAX_WIDTH_DEF        = 1024;
    localparam int MAX_HEIGHT_DEF       = 1024;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    localparam logic [DIM_W-1:0] WIDTH_RESET     = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET    = DIM_W'(480);
    localparam logic [THR_W-1:0] THRESHOLD_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_CALM_THRESHOLD = 2'd2
    } ghfc_cfg_t;

    // Control of a beat between the line store read and the weight lookup.
    typedef struct packed {
        logic valid;
        logic pair_en;
        logic frame_end;
    } ghfc_s1_t;

    // Control of a beat between the weight lookup and the accumulator.
    typedef struct packed {
        logic valid;
        logic frame_end;
    } ghfc_s2_t;

endpackage : ghfc_pkg
`default_nettype wire

// ----- hw/rtl/ghfc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ghfc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered, read enable holds
// the last read word.
// ----------------------------------------------------------------------------
module ghfc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output      logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : ghfc_ram
`default_nettype wire

// ----- hw/rtl/ghfc_weight.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ghfc_weight: pair weight lookup stage
// Takes the absolute difference of a pixel and its up-right neighbor and
// looks up round(2^F / (1 + d*d)) in a constant table.
// ----------------------------------------------------------------------------
module ghfc_weight
    import ghfc_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
    localparam int WGT_W = WEIGHT_FRAC_BITS + 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire ghfc_s1_t         s1_ctl,
    input  wire logic [PIX_W-1:0] s1_pix,
    input  wire logic [PIX_W-1:0] up_pix,
    output      ghfc_s2_t         s2_ctl,
    output      logic [WGT_W-1:0] s2_weight
);

    localparam longint unsigned ONE = 64'd1 << WEIGHT_FRAC_BITS;

    logic [WGT_W-1:0] weight_tab [GRAY_LEVELS];
    logic [PIX_W-1:0] diff;
    ghfc_s2_t         ctl_reg;
    ghfc_s2_t         ctl_next;
    logic [WGT_W-1:0] weight_reg;
    logic [WGT_W-1:0] weight_next;

    // Table entry d holds (2^F + q/2) / q with q = 1 + d*d, rounded half up.
    for (genvar g = 0; g < GRAY_LEVELS; g++)
    begin : g_tab
        localparam longint unsigned Q = 64'd1 + longint'(g) * longint'(g);
        assign weight_tab[g] = WGT_W'((ONE + Q / 2) / Q);
    end

    always_comb
    begin
        diff        = (s1_pix > up_pix) ? (s1_pix - up_pix) : (up_pix - s1_pix);
        weight_next = s1_ctl.pair_en ? weight_tab[diff] : '0;
        ctl_next    = '{valid: s1_ctl.valid, frame_end: s1_ctl.frame_end};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            weight_reg <= weight_next;
        end
    end

    assign s2_ctl    = ctl_reg;
    assign s2_weight = weight_reg;

endmodule : ghfc_weight
`default_nettype wire

// ----- hw/rtl/ghfc_accum.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ghfc_accum: weight accumulator and result register
// Sums pair weights with saturation, forms the fire limit from the frame
// size and threshold, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module ghfc_accum
    import ghfc_pkg::*;
#(
    parameter int MAX_WIDTH        = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT       = MAX_HEIGHT_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
    localparam int CNT_W  = $clog2(MAX_WIDTH),
    localparam int RCNT_W = $clog2(MAX_HEIGHT),
    localparam int WGT_W  = WEIGHT_FRAC_BITS + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ghfc_s2_t          s2_ctl,
    input  wire logic [WGT_W-1:0]  s2_weight,
    input  wire logic [CNT_W-1:0]  wm1,
    input  wire logic [RCNT_W-1:0] hm1,
    input  wire logic [THR_W-1:0]  threshold,
    input  wire logic              out_stall,
    output      logic              out_valid,
    output      logic [SUM_W-1:0]  weighted_sum,
    output      logic              fire_flag,
    output      logic              blocked
);

    localparam int PROD_W = CNT_W + RCNT_W;
    localparam int LIM_W  = THR_W + PROD_W + 1;
    localparam int CMP_W  = (LIM_W > SUM_W) ? LIM_W : SUM_W;

    logic [PROD_W-1:0] prod_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W:0]    sum_wide;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SUM_W-1:0]  res_sum_reg;
    logic              res_flag_reg;
    logic              emit;
    logic              step;

    // The limit is 2*(W-1)*(H-1)*threshold, formed in two registered multiplies.
    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(wm1) * PROD_W'(hm1);
        limit_reg <= {(LIM_W - 1)'((LIM_W - 1)'(threshold) * (LIM_W - 1)'(prod_reg)), 1'b0};
    end

    always_comb
    begin
        blocked  = s2_ctl.valid && s2_ctl.frame_end && out_valid_reg && out_stall;
        step     = s2_ctl.valid && !blocked;
        emit     = step && s2_ctl.frame_end;
        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(s2_weight);
        sum_next = sum_reg;
        if (step)
        begin
            if (s2_ctl.frame_end)
            begin
                sum_next = '0;
            end
            else if (sum_wide[SUM_W])
            begin
                sum_next = '1;
            end
            else
            begin
                sum_next = sum_wide[SUM_W-1:0];
            end
        end
        out_valid_next = out_valid_reg && out_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_sum_reg  <= sum_reg;
            res_flag_reg <= CMP_W'(sum_reg) < CMP_W'(limit_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign weighted_sum = res_sum_reg;
    assign fire_flag    = res_flag_reg;

endmodule : ghfc_accum
`default_nettype wire

// ----- hw/rtl/glcm_homogeneity_fire_check_core.sv -----
// The frame's last pixel passes through the stage one register and the
// weight register before the result register raises out_valid.
// Throughput: one pixel per cycle; the line store takes one write and one read
// each cycle, and input stalls only while an unread result blocks the next one.
// Reset clears the counters, the sum and the output; the line store is not
// cleared, and the registers return to 640 x 480 with a zero threshold.
`default_nettype none
// ----------------------------------------------------------------------------
// glcm_homogeneity_fire_check_core: 45-degree GLCM homogeneity fire check
// Pairs each pixel with its up-right neighbor from a one-line store, sums the
// homogeneity weights over a frame and flags fire when the sum is low.
// ----------------------------------------------------------------------------
module glcm_homogeneity_fire_check_core
    import ghfc_pkg::*;
#(
    parameter int MAX_WIDTH        = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT       = MAX_HEIGHT_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire logic [PIX_W-1:0]     gray_pixel,
    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      logic [SUM_W-1:0]     weighted_sum,
    output      logic                 fire_flag
);

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int RCNT_W = $clog2(MAX_HEIGHT);
    localparam int WL_W   = $clog2(MAX_WIDTH + 1);
    localparam int HL_W   = $clog2(MAX_HEIGHT + 1);
    localparam int WGT_W  = WEIGHT_FRAC_BITS + 1;

    // Configuration registers.
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [THR_W-1:0] thr_reg;

    // Frame size in use, clamped to the legal range, minus one.
    logic [WL_W-1:0]   w_lim;
    logic [HL_W-1:0]   h_lim;
    logic [CNT_W-1:0]  wm1;
    logic [RCNT_W-1:0] hm1;

    // Raster position of the next pixel.
    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  col_next;
    logic [RCNT_W-1:0] row_reg;
    logic [RCNT_W-1:0] row_next;

    logic              in_accept;
    logic              line_end;
    logic              last_row;
    logic              blocked;
    logic              advance;
    logic [CNT_W-1:0]  rd_addr;
    logic [PIX_W-1:0]  up_pix;

    // Stage one: the pixel waits here while the line store read completes.
    ghfc_s1_t          s1_reg;
    ghfc_s1_t          s1_next;
    logic [PIX_W-1:0]  s1_pix_reg;

    ghfc_s2_t          s2_ctl;
    logic [WGT_W-1:0]  s2_weight;

    // ------------------------------------------------------------------------
    // Configuration port. Writes to an index past the register list are
    // dropped.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thr_reg    <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (ghfc_cfg_t'(cfg_index))
                CFG_FRAME_WIDTH:    width_reg  <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT:   height_reg <= cfg_data[DIM_W-1:0];
                CFG_CALM_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // Clamp the frame size into [2, MAX]. This is combinational so that a
    // pixel accepted right after a register write already sees the new size.
    always_comb
    begin
        priority if (32'(width_reg) < MIN_DIM)
        begin
            w_lim = WL_W'(MIN_DIM);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_lim = WL_W'(MAX_WIDTH);
        end
        else
        begin
            w_lim = WL_W'(width_reg);
        end

        priority if (32'(height_reg) < MIN_DIM)
        begin
            h_lim = HL_W'(MIN_DIM);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_lim = HL_W'(MAX_HEIGHT);
        end
        else
        begin
            h_lim = HL_W'(height_reg);
        end

        wm1 = CNT_W'(w_lim - WL_W'(1));
        hm1 = RCNT_W'(h_lim - HL_W'(1));
    end

    // ------------------------------------------------------------------------
    // Input side and raster counters. The pipeline freezes as a whole only
    // when a frame result reaches the accumulator while the previous result
    // is still held on the output.
    // ------------------------------------------------------------------------
    always_comb
    begin
        advance   = !blocked;
        in_stall  = blocked;
        in_accept = in_valid && !blocked;
        line_end  = col_reg >= wm1;
        last_row  = row_reg >= hm1;
        rd_addr   = col_reg + CNT_W'(1);

        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (line_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RCNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end

        s1_next = '{
            valid:     in_accept,
            pair_en:   (row_reg != '0) && !line_end,
            frame_end: line_end && last_row
        };
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s1_reg  <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (advance)
            begin
                s1_reg <= s1_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg <= gray_pixel;
        end
    end

    // ------------------------------------------------------------------------
    // Line store. Each accepted pixel overwrites its own column and reads the
    // column to its right, which still holds the previous line. The two
    // addresses never match on a paired pixel, and every earlier write has
    // landed before the read, so no forwarding is needed. The read enable
    // follows the accept, so the read word holds while the pipeline is frozen.
    // ------------------------------------------------------------------------
    ghfc_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (in_accept),
        .waddr (col_reg),
        .wdata (gray_pixel),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (up_pix)
    );

    // Stage two: difference and weight lookup.
    ghfc_weight #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .s1_ctl    (s1_reg),
        .s1_pix    (s1_pix_reg),
        .up_pix    (up_pix),
        .s2_ctl    (s2_ctl),
        .s2_weight (s2_weight)
    );

    // Stage three: accumulation, fire limit and the result register.
    ghfc_accum #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_HEIGHT       (MAX_HEIGHT),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .s2_ctl       (s2_ctl),
        .s2_weight    (s2_weight),
        .wm1          (wm1),
        .hm1          (hm1),
        .threshold    (thr_reg),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .weighted_sum (weighted_sum),
        .fire_flag    (fire_flag),
        .blocked      (blocked)
    );

`ifndef ASSERT_OFF
    a_addr_apart: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !line_end |-> rd_addr != col_reg)
        else $error("line store read and write hit the same column");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && line_end && last_row |=> col_reg == '0 && row_reg == '0)
        else $error("raster counters did not wrap at frame end");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && s2_ctl.valid && s2_ctl.frame_end)
        else $error("input stalled without a blocked result");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !line_end |=> col_reg <= wm1 || $changed(wm1))
        else $error("column counter ran past the line end");
`endif

endmodule : glcm_homogeneity_fire_check_core
`default_nettype wire

// ----- tb/ghfc_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghfc_frame_checker: result predictor and scoreboard for the fire check core
// Watches the register port and both channels, predicts the weighted sum and
// fire flag of every frame and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
module ghfc_frame_checker
    import ghfc_pkg::*;
#(
    parameter int MAX_WIDTH        = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT       = MAX_HEIGHT_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic [PIX_W-1:0]     gray_pixel,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [SUM_W-1:0]     weighted_sum,
    input  wire logic                 fire_flag,
    output int                        fail_count,
    output int                        pending,
    output int                        frames_checked
);

    localparam logic [SUM_W:0] SUM_CEILING = {1'b0, {SUM_W{1'b1}}};

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             fire;
    } frame_result_t;

    frame_result_t    frame_results [$];
    logic [PIX_W-1:0] upper_line [MAX_WIDTH];
    logic [SUM_W:0]   frame_sum;
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [THR_W-1:0] threshold_reg;

    initial
    begin
        fail_count     = 0;
        pending        = 0;
        frames_checked = 0;
    end

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    // Q16 closeness of two gray levels, rounded half up.
    function automatic longint unsigned pair_closeness(int unsigned a, int unsigned b);
        int unsigned       d;
        longint unsigned   q;
        d = (a > b) ? a - b : b - a;
        q = 64'd1 + 64'(d) * 64'(d);
        return ((64'd1 << WEIGHT_FRAC_BITS) + q / 2) / q;
    endfunction

    task automatic take_pixel(input logic [PIX_W-1:0] pix);
        int unsigned     w;
        int unsigned     h;
        int unsigned     col;
        logic            line_end;
        longint unsigned fire_limit;
        frame_result_t   res;
        w        = clamp_dim(width_reg, MAX_WIDTH);
        h        = clamp_dim(height_reg, MAX_HEIGHT);
        col      = col_pos;
        line_end = (col >= w - 1);
        if (row_pos >= 1 && !line_end)
        begin
            frame_sum = (SUM_W + 1)'(64'(frame_sum)
                                     + pair_closeness(pix, upper_line[col + 1]));
            if (frame_sum > SUM_CEILING)
                frame_sum = SUM_CEILING;
        end
        if (col < MAX_WIDTH)
            upper_line[col] = pix;
        if (line_end)
        begin
            col_pos = 0;
            if (row_pos >= h - 1)
            begin
                fire_limit = 64'(threshold_reg) * 64'(2 * (w - 1) * (h - 1));
                res.sum    = frame_sum[SUM_W-1:0];
                res.fire   = (64'(frame_sum) < fire_limit);
                frame_results.push_back(res);
                frame_sum = '0;
                row_pos   = 0;
            end
            else
                row_pos = row_pos + 1;
        end
        else
            col_pos = col + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            frame_results.delete();
            frame_sum     = '0;
            col_pos       = 0;
            row_pos       = 0;
            width_reg     = WIDTH_RESET;
            height_reg    = HEIGHT_RESET;
            threshold_reg = THRESHOLD_RESET;
        end
        else
        begin
            // Results are compared before this edge's pixel is taken, so a
            // beat can never be matched against its own expectation.
            if (out_valid && !out_stall)
            begin
                if (frame_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat with none expected: sum %0d fire %0b",
                             $time, weighted_sum, fire_flag);
                end
                else
                begin
                    want = frame_results.pop_front();
                    frames_checked++;
                    if (weighted_sum !== want.sum)
                    begin
                        fail_count++;
                        $display("%0t: weighted_sum expected %0d actual %0d",
                                 $time, want.sum, weighted_sum);
                    end
                    if (fire_flag !== want.fire)
                    begin
                        fail_count++;
                        $display("%0t: fire_flag expected %0b actual %0b",
                                 $time, want.fire, fire_flag);
                    end
                end
            end
            if (in_valid && !in_stall)
                take_pixel(gray_pixel);
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:    width_reg     = cfg_data[DIM_W-1:0];
                    CFG_FRAME_HEIGHT:   height_reg    = cfg_data[DIM_W-1:0];
                    CFG_CALM_THRESHOLD: threshold_reg = cfg_data[THR_W-1:0];
                    default:            ;
                endcase
            end
        end
        pending = frame_results.size();
    end

endmodule : ghfc_frame_checker

// ----- tb/glcm_homogeneity_fire_check_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcm_homogeneity_fire_check_core_tb: frame-level test of the fire check core
// Streams whole frames of gray pixels at many sizes, thresholds and image
// textures through the core while both channels idle at random, and lets the
// frame checker compare every sum and fire flag with its own prediction.
// ----------------------------------------------------------------------------
module glcm_homogeneity_fire_check_core_tb;
    import ghfc_pkg::*;

    // Longest stretch of cycles without any beat before the run is given up.
    // A correct run never comes near it, even with 70% idling on a channel.
    localparam int QUIET_LIMIT   = 5000;
    // Margin kept after the core has shown its last expected result.
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PIXELS = 560;
    localparam int MIN_FRAMES    = 6;
    // Long side of the thin frames sent in the idling phases.
    localparam int LONG_SIDE     = 128;
    // Register index with no register behind it; a write there changes nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [THR_W-1:0]     THR_MAX   = '1;

    typedef enum int {
        IMG_FLAT,
        IMG_SMOOTH,
        IMG_NOISE,
        IMG_SPECKLE
    } image_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIX_W-1:0]     gray_pixel;
    logic                 out_valid;
    logic                 out_stall;
    logic [SUM_W-1:0]     weighted_sum;
    logic                 fire_flag;

    int fail_count;
    int pending;
    int frames_checked;

    // Percent chance per cycle that the sender holds back a pixel, and that
    // the receiver stalls the result channel.
    int idle_pct;
    int stall_pct;
    // Frame size in use after clamping, tracked so that only whole frames
    // are sent and no register changes in the middle of one.
    int eff_w;
    int eff_h;
    int pixels_sent;
    int reg_writes;
    int quiet_cycles;

    glcm_homogeneity_fire_check_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .gray_pixel   (gray_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .weighted_sum (weighted_sum),
        .fire_flag    (fire_flag)
    );

    ghfc_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .gray_pixel     (gray_pixel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .weighted_sum   (weighted_sum),
        .fire_flag      (fire_flag),
        .fail_count     (fail_count),
        .pending        (pending),
        .frames_checked (frames_checked)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // The receiver decides at each falling edge whether to stall the next
    // rising edge, so the stall is stable well before it is sampled.
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Watchdog: any accepted beat or register write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    function automatic int fit_dim(logic [DIM_W-1:0] v, int maxv);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > maxv)
            return maxv;
        return int'(v);
    endfunction

    // Offers one pixel beat and returns at the falling edge after it was
    // accepted. Valid stays high into the next call unless that call idles,
    // so each falling edge sees at most one assignment to valid.
    task automatic push_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        gray_pixel <= pix;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Lowers valid and waits until every frame sent so far has produced its
    // result, plus a short margin, so that registers change only while idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write beat; write enable drops for a cycle between writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        reg_writes++;
        if (idx == CFG_FRAME_WIDTH)
            eff_w = fit_dim(data[DIM_W-1:0], MAX_WIDTH_DEF);
        else if (idx == CFG_FRAME_HEIGHT)
            eff_h = fit_dim(data[DIM_W-1:0], MAX_HEIGHT_DEF);
    endtask

    // Sends up to nine hand-picked pixels, first pixel in the top byte.
    task automatic push_packed(input logic [9*PIX_W-1:0] pixels, input int count);
        int k;
        for (k = 0; k < count; k++)
            push_pixel(pixels[(8 - k)*PIX_W +: PIX_W]);
    endtask

    // Sends one whole frame at the size in use. Flat and smooth images give
    // large weights (calm scenes), noise gives tiny ones (flickering fire),
    // and speckle sits in between.
    task automatic run_frame(input image_mode_t mode);
        int               n;
        int               walk;
        int               base;
        logic [PIX_W-1:0] pix;
        base = int'($urandom_range(0, 255));
        walk = base;
        for (n = 0; n < eff_w * eff_h; n++)
        begin
            case (mode)
                IMG_FLAT:
                    pix = PIX_W'(base);
                IMG_SMOOTH:
                begin
                    walk = walk + int'($urandom_range(0, 4)) - 2;
                    if (walk < 0)
                        walk = 0;
                    if (walk > 255)
                        walk = 255;
                    pix = PIX_W'(walk);
                end
                IMG_NOISE:
                    pix = PIX_W'($urandom_range(0, 255));
                default:
                    pix = ($urandom_range(0, 9) == 0) ? PIX_W'($urandom_range(0, 255))
                                                      : PIX_W'(base);
            endcase
            push_pixel(pix);
        end
    endtask

    // Between frames, maybe change some registers. Frames with no change
    // follow each other back to back, so the frame boundary is also crossed
    // while pixels keep streaming.
    task automatic random_setup();
        logic             do_w;
        logic             do_h;
        logic             do_t;
        logic [CFG_W-1:0] data;
        int               pick;
        do_w = ($urandom_range(0, 2) == 0);
        do_h = ($urandom_range(0, 2) == 0);
        do_t = ($urandom_range(0, 1) == 0);
        if (!(do_w || do_h || do_t))
            return;
        settle();
        if (do_w)
        begin
            pick = int'($urandom_range(0, 19));
            data = '0;
            if (pick == 0)
                data[DIM_W-1:0] = DIM_W'(0);
            else if (pick == 1)
                data[DIM_W-1:0] = DIM_W'(1);
            else
                data[DIM_W-1:0] = DIM_W'($urandom_range(2, 9));
            // Bits above the register's width must be ignored.
            if ($urandom_range(0, 7) == 0)
                data[CFG_W-1:DIM_W] = (CFG_W - DIM_W)'($urandom);
            write_reg(CFG_FRAME_WIDTH, data);
        end
        if (do_h)
        begin
            data = '0;
            data[DIM_W-1:0] = DIM_W'($urandom_range(0, 6));
            if ($urandom_range(0, 7) == 0)
                data[CFG_W-1:DIM_W] = (CFG_W - DIM_W)'($urandom);
            write_reg(CFG_FRAME_HEIGHT, data);
        end
        if (do_t)
        begin
            pick = int'($urandom_range(0, 5));
            if (pick == 0)
                data = '0;
            else if (pick == 1)
                data = THR_MAX;
            else if (pick == 2)
                data = CFG_W'($urandom_range(0, 2000));
            else if (pick == 5)
                data = CFG_W'($urandom_range(0, int'(THR_MAX)));
            else
                data = CFG_W'($urandom_range(6000, 36000));
            write_reg(CFG_CALM_THRESHOLD, data);
        end
    endtask

    initial
    begin
        int phase;
        int frames;
        int start_pixels;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_FRAME_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        gray_pixel   = '0;
        out_stall    = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        eff_w        = int'(WIDTH_RESET);
        eff_h        = int'(HEIGHT_RESET);
        pixels_sent  = 0;
        reg_writes   = 0;
        quiet_cycles = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed frames. The threshold is still at its reset value of zero,
        // so the first two frames must never flag fire. Identical neighbors
        // give the full weight, the darkest against the brightest gives one.
        write_reg(CFG_FRAME_WIDTH, 2);
        write_reg(CFG_FRAME_HEIGHT, 2);
        push_packed({8'd0, 8'd0, 8'd0, 8'd255, 40'd0}, 4);
        push_packed({8'd0, 8'd255, 8'd0, 8'd0, 40'd0}, 4);
        settle();

        // Sizes below the minimum clamp to two; the top threshold flags even
        // a perfectly flat frame. The spare index must leave everything alone.
        write_reg(CFG_FRAME_WIDTH, 1);
        write_reg(CFG_FRAME_HEIGHT, 0);
        write_reg(CFG_CALM_THRESHOLD, THR_MAX);
        write_reg(CFG_SPARE, '1);
        push_packed({8'd255, 8'd255, 8'd255, 8'd0, 40'd0}, 4);
        settle();

        // A 3 x 3 frame at a threshold of one half, with small and large steps.
        write_reg(CFG_FRAME_WIDTH, 3);
        write_reg(CFG_FRAME_HEIGHT, 3);
        write_reg(CFG_CALM_THRESHOLD, 32768);
        push_packed({8'd10, 8'd11, 8'd12, 8'd13, 8'd12, 8'd11, 8'd10, 8'd200, 8'd255}, 9);

        // Random frames in four idling phases: none, a slow sender, a slow
        // receiver, then both. Phase two and four also carry one thin frame,
        // long in height and then in width, two pixels on the other side.
        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 29 : 0;
            stall_pct = (phase == 2) ? 70 : (phase == 3) ? 29 : 0;
            frames       = 0;
            start_pixels = pixels_sent;
            while (pixels_sent - start_pixels < RANDOM_PIXELS / 4 || frames < MIN_FRAMES)
            begin
                random_setup();
                run_frame(image_mode_t'($urandom_range(0, 3)));
                frames++;
            end
            if (phase == 1 || phase == 3)
            begin
                settle();
                write_reg(CFG_FRAME_WIDTH, (phase == 1) ? CFG_W'(2) : CFG_W'(LONG_SIDE));
                write_reg(CFG_FRAME_HEIGHT, (phase == 1) ? CFG_W'(LONG_SIDE) : CFG_W'(2));
                write_reg(CFG_CALM_THRESHOLD, CFG_W'($urandom_range(10000, 30000)));
                run_frame((phase == 1) ? IMG_SMOOTH : IMG_NOISE);
                settle();
                write_reg(CFG_FRAME_WIDTH, 4);
                write_reg(CFG_FRAME_HEIGHT, 3);
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d pixels and %0d register writes; %0d frame results compared.",
                 pixels_sent, reg_writes, frames_checked);
        $display("Frames ranged from 2 x 2 to %0d pixels on a side, under four idling mixes.",
                 LONG_SIDE);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule : glcm_homogeneity_fire_check_core_tb
